[sv/jtl_pkg.sv]
package jtl_pkg;

  // Characters the lexer looks at
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACK    = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK    = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_E         = 8'h65;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_L         = 8'h6C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_S         = 8'h73;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  // Keyword selects
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  // Result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    ST_TOKEN        = 3'd0,
    ST_END          = 3'd1,
    ST_BAD_NUMBER   = 3'd2,
    ST_OPEN_COMMENT = 3'd3,
    ST_BAD_STRING   = 3'd4,
    ST_UNKNOWN      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    K_LBRACK = 4'd0,
    K_RBRACK = 4'd1,
    K_LBRACE = 4'd2,
    K_RBRACE = 4'd3,
    K_COMMA  = 4'd4,
    K_COLON  = 4'd5,
    K_STRING = 4'd6,
    K_INT    = 4'd7,
    K_REAL   = 4'd8,
    K_TRUE   = 4'd9,
    K_FALSE  = 4'd10,
    K_NULL   = 4'd11
  } token_kind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SLASH, S_LINE, S_BLOCK, S_BSTAR, S_STRING, S_KEYWORD,
    S_NMINUS, S_NZERO, S_NINT, S_NDOT, S_NFRAC
  } scan_state_e;

  typedef enum logic [3:0] {
    C_SPACE, C_SLASH, C_SINGLE, C_QUOTE, C_MINUS, C_ZERO, C_DIGIT, C_KEYWORD,
    C_OTHER
  } byte_class_e;

  typedef struct packed {
    byte_class_e cls;
    token_kind_e kind;
    logic [1:0]  kw_sel;
  } byte_class_t;

  typedef struct packed {
    status_e     status;
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] len;
  } result_t;

  // Up to two results per beat, first slot filled first
  typedef struct packed {
    logic    first;
    logic    second;
    result_t r0;
    result_t r1;
  } qpush_t;

  function automatic byte_class_t jtl_classify(input logic [7:0] c);
    byte_class_t r;
    r.cls    = C_OTHER;
    r.kind   = K_LBRACK;
    r.kw_sel = KW_TRUE;
    unique case (c)
      CH_SPACE, CH_TAB, CH_NL: r.cls = C_SPACE;
      CH_SLASH:  r.cls = C_SLASH;
      CH_LBRACK: begin r.cls = C_SINGLE; r.kind = K_LBRACK; end
      CH_RBRACK: begin r.cls = C_SINGLE; r.kind = K_RBRACK; end
      CH_LBRACE: begin r.cls = C_SINGLE; r.kind = K_LBRACE; end
      CH_RBRACE: begin r.cls = C_SINGLE; r.kind = K_RBRACE; end
      CH_COMMA:  begin r.cls = C_SINGLE; r.kind = K_COMMA; end
      CH_COLON:  begin r.cls = C_SINGLE; r.kind = K_COLON; end
      CH_QUOTE:  r.cls = C_QUOTE;
      CH_MINUS:  r.cls = C_MINUS;
      CH_0:      r.cls = C_ZERO;
      CH_T:      begin r.cls = C_KEYWORD; r.kw_sel = KW_TRUE; end
      CH_F:      begin r.cls = C_KEYWORD; r.kw_sel = KW_FALSE; end
      CH_N:      begin r.cls = C_KEYWORD; r.kw_sel = KW_NULL; end
      default: begin
        if (c > CH_0 && c <= CH_9) r.cls = C_DIGIT;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] jtl_kw_char(input logic [1:0] sel, input logic [2:0] k);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (sel)
      KW_FALSE: begin
        unique case (k)
          3'd0: ch = CH_F;
          3'd1: ch = CH_A;
          3'd2: ch = CH_L;
          3'd3: ch = CH_S;
          3'd4: ch = CH_E;
          default: ch = 8'h00;
        endcase
      end
      KW_NULL: begin
        unique case (k)
          3'd0: ch = CH_N;
          3'd1: ch = CH_U;
          3'd2: ch = CH_L;
          3'd3: ch = CH_L;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (k)
          3'd0: ch = CH_T;
          3'd1: ch = CH_R;
          3'd2: ch = CH_U;
          3'd3: ch = CH_E;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] jtl_kw_len(input logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

[sv/jtl_scan.sv]
module jtl_scan
  import jtl_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  output qpush_t     push_o
);

  localparam logic [OFFSET_BITS-1:0] OffMax = '1;

  scan_state_e            state_q, state_d;
  logic [1:0]             kw_sel_q, kw_sel_d;
  logic [2:0]             kw_prog_q, kw_prog_d;
  logic                   bslash_q, bslash_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   err_q, err_d;

  byte_class_t            cls;
  logic                   is_dig;
  logic                   kw_hit, kw_last;
  logic [2:0]             kw_prog_inc;
  logic [OFFSET_BITS-1:0] inc_pos, span_here, span_incl, span_one;
  logic                   redo;
  result_t                res_a, res_b, res_e;
  logic                   a_vld, b_vld;
  logic                   live;
  token_kind_e            kw_kind;

  function automatic logic [15:0] clip16(input logic [OFFSET_BITS-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    return (wide > 33'h0FFFF) ? 16'hFFFF : wide[15:0];
  endfunction

  function automatic result_t mk_tok(input token_kind_e k, input logic [OFFSET_BITS-1:0] s,
                                     input logic [OFFSET_BITS-1:0] l);
    result_t r;
    r.status = ST_TOKEN;
    r.kind   = k;
    r.start  = clip16(s);
    r.len    = clip16(l);
    return r;
  endfunction

  function automatic result_t mk_err(input status_e st, input logic [OFFSET_BITS-1:0] s);
    result_t r;
    r.status = st;
    r.kind   = K_LBRACK;
    r.start  = clip16(s);
    r.len    = 16'd0;
    return r;
  endfunction

  assign cls         = jtl_classify(byte_i);
  assign is_dig      = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign inc_pos     = (off_q == OffMax) ? off_q : off_q + OFFSET_BITS'(1);
  assign span_here   = off_q - start_q;
  assign span_incl   = inc_pos - start_q;
  assign span_one    = inc_pos - off_q;
  assign kw_prog_inc = kw_prog_q + 3'd1;
  assign kw_hit      = (kw_prog_q < jtl_kw_len(kw_sel_q))
                       && (jtl_kw_char(kw_sel_q, kw_prog_q) == byte_i);
  assign kw_last     = kw_hit && (kw_prog_inc == jtl_kw_len(kw_sel_q));
  assign kw_kind     = (kw_sel_q == KW_FALSE) ? K_FALSE :
                       (kw_sel_q == KW_NULL)  ? K_NULL  : K_TRUE;

  // Decode: result of the current construct, and whether the byte restarts from idle
  always_comb begin
    res_a = mk_err(ST_UNKNOWN, start_q);
    a_vld = 1'b0;
    redo  = 1'b0;
    if (eot_i) begin
      unique case (state_q)
        S_NZERO, S_NINT: begin res_a = mk_tok(K_INT, start_q, span_here); a_vld = 1'b1; end
        S_NFRAC: begin res_a = mk_tok(K_REAL, start_q, span_here); a_vld = 1'b1; end
        S_NMINUS, S_NDOT: begin res_a = mk_err(ST_BAD_NUMBER, start_q); a_vld = 1'b1; end
        S_BLOCK, S_BSTAR: begin res_a = mk_err(ST_OPEN_COMMENT, start_q); a_vld = 1'b1; end
        S_STRING: begin res_a = mk_err(ST_BAD_STRING, start_q); a_vld = 1'b1; end
        S_SLASH, S_KEYWORD: begin res_a = mk_err(ST_UNKNOWN, start_q); a_vld = 1'b1; end
        default: a_vld = 1'b0;
      endcase
    end else begin
      unique case (state_q)
        S_IDLE: redo = 1'b1;
        S_SLASH: a_vld = (byte_i != CH_SLASH) && (byte_i != CH_STAR);
        S_STRING: begin
          res_a = mk_tok(K_STRING, start_q, span_incl);
          a_vld = (byte_i == CH_QUOTE) && !bslash_q;
        end
        S_KEYWORD: begin
          if (!kw_hit) begin
            a_vld = 1'b1;
          end else if (kw_last) begin
            res_a = mk_tok(kw_kind, start_q, span_incl);
            a_vld = 1'b1;
          end
        end
        S_NMINUS, S_NDOT: begin
          res_a = mk_err(ST_BAD_NUMBER, start_q);
          a_vld = !is_dig;
        end
        S_NZERO: begin
          res_a = mk_tok(K_INT, start_q, span_here);
          a_vld = (byte_i != CH_DOT);
          redo  = a_vld;
        end
        S_NINT: begin
          res_a = mk_tok(K_INT, start_q, span_here);
          a_vld = (byte_i != CH_DOT) && !is_dig;
          redo  = a_vld;
        end
        S_NFRAC: begin
          res_a = mk_tok(K_REAL, start_q, span_here);
          a_vld = !is_dig;
          redo  = a_vld;
        end
        default: a_vld = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d   = state_q;
    kw_sel_d  = kw_sel_q;
    kw_prog_d = kw_prog_q;
    bslash_d  = bslash_q;
    off_d     = off_q;
    start_d   = start_q;
    err_d     = err_q;
    if (acc_i) begin
      if (eot_i) begin
        state_d   = S_IDLE;
        kw_sel_d  = KW_TRUE;
        kw_prog_d = 3'd0;
        bslash_d  = 1'b0;
        off_d     = '0;
        start_d   = '0;
        err_d     = 1'b0;
      end else begin
        off_d = inc_pos;
        if (!err_q) begin
          unique case (state_q)
            S_SLASH: begin
              if (byte_i == CH_SLASH) state_d = S_LINE;
              else if (byte_i == CH_STAR) state_d = S_BLOCK;
              else begin state_d = S_IDLE; err_d = 1'b1; end
            end
            S_LINE: if (byte_i == CH_NL) state_d = S_IDLE;
            S_BLOCK: if (byte_i == CH_STAR) state_d = S_BSTAR;
            S_BSTAR: begin
              if (byte_i == CH_SLASH) state_d = S_IDLE;
              else if (byte_i != CH_STAR) state_d = S_BLOCK;
            end
            S_STRING: begin
              if (byte_i == CH_QUOTE && !bslash_q) state_d = S_IDLE;
              bslash_d = (byte_i == CH_BACKSLASH);
            end
            S_KEYWORD: begin
              if (!kw_hit) begin
                state_d = S_IDLE;
                err_d   = 1'b1;
              end else if (kw_last) begin
                state_d   = S_IDLE;
                kw_prog_d = 3'd0;
              end else begin
                kw_prog_d = kw_prog_inc;
              end
            end
            S_NMINUS: begin
              if (byte_i == CH_0) state_d = S_NZERO;
              else if (is_dig) state_d = S_NINT;
              else begin state_d = S_IDLE; err_d = 1'b1; end
            end
            S_NZERO, S_NINT: if (byte_i == CH_DOT) state_d = S_NDOT;
            S_NDOT: begin
              if (is_dig) state_d = S_NFRAC;
              else begin state_d = S_IDLE; err_d = 1'b1; end
            end
            default: state_d = state_q;
          endcase
          // Lex the byte from scratch: idle, or a number ended by it
          if (redo) begin
            start_d = off_q;
            unique case (cls.cls)
              C_SLASH: state_d = S_SLASH;
              C_QUOTE: begin state_d = S_STRING; bslash_d = 1'b0; end
              C_MINUS: state_d = S_NMINUS;
              C_ZERO:  state_d = S_NZERO;
              C_DIGIT: state_d = S_NINT;
              C_KEYWORD: begin
                state_d   = S_KEYWORD;
                kw_sel_d  = cls.kw_sel;
                kw_prog_d = 3'd1;
              end
              C_OTHER: begin state_d = S_IDLE; err_d = 1'b1; end
              default: state_d = S_IDLE;
            endcase
          end
        end
      end
    end
  end

  // Outputs: results pushed into the queue for this beat
  always_comb begin
    live  = acc_i && !err_q;
    res_b = mk_tok(cls.kind, off_q, span_one);
    b_vld = 1'b0;
    if (cls.cls == C_SINGLE) begin
      b_vld = 1'b1;
    end else if (cls.cls == C_OTHER) begin
      res_b = mk_err(ST_UNKNOWN, off_q);
      b_vld = 1'b1;
    end
    res_e = mk_err(ST_END, off_q);

    push_o.first  = (live && a_vld) || (live && redo && b_vld) || (acc_i && eot_i);
    push_o.second = live && a_vld && ((redo && b_vld) || eot_i);
    push_o.r0     = (live && a_vld) ? res_a : (eot_i ? res_e : res_b);
    push_o.r1     = eot_i ? res_e : res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kw_sel_q  <= KW_TRUE;
      kw_prog_q <= 3'd0;
      bslash_q  <= 1'b0;
      off_q     <= '0;
      start_q   <= '0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      kw_sel_q  <= kw_sel_d;
      kw_prog_q <= kw_prog_d;
      bslash_q  <= bslash_d;
      off_q     <= off_d;
      start_q   <= start_d;
      err_q     <= err_d;
    end
  end

endmodule

[sv/jtl_queue.sv]
module jtl_queue
  import jtl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  qpush_t  push_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output logic    room_o
);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic [1:0]       n_push;

  assign n_push  = {1'b0, push_i.first} + {1'b0, push_i.second};
  assign wr_nxt  = wr_q + QPtrW'(1);
  assign wr_d    = wr_q + QPtrW'(n_push);
  assign rd_d    = rd_q + QPtrW'(pop_i);
  assign cnt_d   = cnt_q + (QPtrW+1)'(n_push) - (QPtrW+1)'(pop_i);
  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  // Take a beat only with space for its two possible results
  assign room_o  = (cnt_q <= (QPtrW+1)'(QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) mem_q[wr_q] <= push_i.r0;
    if (push_i.second) mem_q[wr_nxt] <= push_i.r1;
  end

endmodule

[sv/json_token_lexer.sv]
// JSON token lexer: takes one text byte per beat (tlast marks the end-of-text beat, whose
// data byte is ignored) and emits tokens with kind, start offset and length, skipping
// white space and line or block comments. It sustains one byte per cycle; the scanner
// turns each byte into at most two results in the cycle it is accepted, and they are
// written into a four-entry result queue that feeds the output. The input stalls only
// while fewer than two queue entries are free, i.e. when the output side is held off.
// A byte that ends a number and is itself a token or an error gives two results, as does
// end of text after an open construct. After an error no results appear until the end of
// text beat, which always reports the byte count and restarts the offset at zero.
module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [3:0] token_kind, [19:4] start_offset,
                                        // [35:20] token_length, [39:36] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  logic    in_acc;
  logic    out_pop;
  logic    room;
  qpush_t  push;
  result_t head;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = room;

  jtl_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .byte_i (s_axis_tdata_i),
    .eot_i  (s_axis_tlast_i),
    .push_o (push)
  );

  jtl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_pop),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .room_o  (room)
  );

  assign m_axis_tdata_o = {4'd0, head.len, head.start, head.kind};
  assign m_axis_tuser_o = head.status;

  a_push_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |-> !push.first)
    else $error("result pushed without an accepted beat");

  a_end_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |->
      (push.second ? push.r1.status == ST_END : push.first && push.r0.status == ST_END))
    else $error("end of text beat did not end with an end result");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && head.status != ST_TOKEN |->
      head.kind == K_LBRACK && head.len == 16'd0)
    else $error("non-token result carries kind or length");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench
  import jtl_pkg::*;
;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RANDOM_BEATS = 1250;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_PRINTS   = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  json_token_lexer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Lexer shadow state
  scan_state_e lx_state;
  logic [1:0]  lx_kw_sel;
  logic [2:0]  lx_kw_pos;
  logic        lx_escaped;
  logic [15:0] lx_offset;
  logic [15:0] lx_start;
  logic        lx_halted;

  result_t     step_results[$];     // results caused by the byte just accepted
  result_t     pending_results[$];  // results still owed by the lexer
  logic [7:0]  frag_bytes[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  dir_row_t    dir_rows[$];

  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned live_beats = 0;
  int unsigned texts_sent = 0;
  int unsigned results_seen = 0;
  int unsigned tokens_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned ends_seen = 0;
  int unsigned cycle_count = 0;

  function automatic result_t res(input status_e st, input token_kind_e k,
                                  input logic [15:0] s, input logic [15:0] l);
    result_t r;
    r.status = st;
    r.kind   = k;
    r.start  = s;
    r.len    = l;
    return r;
  endfunction

  function automatic logic [15:0] sat_next(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= CH_0 && ch <= CH_9;
  endfunction

  function automatic string keyword_text(input logic [1:0] sel);
    case (sel)
      KW_FALSE: return "false";
      KW_NULL:  return "null";
      default:  return "true";
    endcase
  endfunction

  function automatic void lexer_clear();
    lx_state   = S_IDLE;
    lx_kw_sel  = KW_TRUE;
    lx_kw_pos  = 3'd0;
    lx_escaped = 1'b0;
    lx_offset  = 16'd0;
    lx_start   = 16'd0;
    lx_halted  = 1'b0;
  endfunction

  function automatic void lex_fail(input status_e st);
    step_results.push_back(res(st, K_LBRACK, lx_start, 16'd0));
    lx_halted = 1'b1;
    lx_state  = S_IDLE;
  endfunction

  // Lex a byte as if nothing were pending
  function automatic void lex_fresh(input logic [7:0] ch, input logic [15:0] pos);
    token_kind_e kind;
    logic        single;
    kind   = K_LBRACK;
    single = 1'b0;
    lx_start = pos;
    case (ch)
      CH_SPACE, CH_TAB, CH_NL: ;
      CH_SLASH:  lx_state = S_SLASH;
      CH_LBRACK: begin single = 1'b1; kind = K_LBRACK; end
      CH_RBRACK: begin single = 1'b1; kind = K_RBRACK; end
      CH_LBRACE: begin single = 1'b1; kind = K_LBRACE; end
      CH_RBRACE: begin single = 1'b1; kind = K_RBRACE; end
      CH_COMMA:  begin single = 1'b1; kind = K_COMMA; end
      CH_COLON:  begin single = 1'b1; kind = K_COLON; end
      CH_QUOTE: begin
        lx_state   = S_STRING;
        lx_escaped = 1'b0;
      end
      CH_MINUS: lx_state = S_NMINUS;
      CH_0:     lx_state = S_NZERO;
      CH_T: begin lx_kw_sel = KW_TRUE;  lx_state = S_KEYWORD; lx_kw_pos = 3'd1; end
      CH_F: begin lx_kw_sel = KW_FALSE; lx_state = S_KEYWORD; lx_kw_pos = 3'd1; end
      CH_N: begin lx_kw_sel = KW_NULL;  lx_state = S_KEYWORD; lx_kw_pos = 3'd1; end
      default: begin
        if (is_digit(ch)) lx_state = S_NINT;
        else lex_fail(ST_UNKNOWN);
      end
    endcase
    if (single) step_results.push_back(res(ST_TOKEN, kind, pos, sat_next(pos) - pos));
  endfunction

  // Close a number on the byte that cannot extend it, then relex that byte
  function automatic void number_done(input token_kind_e kind, input logic [7:0] ch,
                                      input logic [15:0] pos);
    step_results.push_back(res(ST_TOKEN, kind, lx_start, pos - lx_start));
    lx_state = S_IDLE;
    lex_fresh(ch, pos);
  endfunction

  function automatic void lex_predict(input logic [7:0] ch, input logic eot);
    logic [15:0] pos;
    string       word;
    token_kind_e kw_kind;
    pos = lx_offset;
    step_results.delete();
    if (eot) begin
      if (!lx_halted) begin
        case (lx_state)
          S_NZERO, S_NINT:
            step_results.push_back(res(ST_TOKEN, K_INT, lx_start, pos - lx_start));
          S_NFRAC:
            step_results.push_back(res(ST_TOKEN, K_REAL, lx_start, pos - lx_start));
          S_NMINUS, S_NDOT:   lex_fail(ST_BAD_NUMBER);
          S_BLOCK, S_BSTAR:   lex_fail(ST_OPEN_COMMENT);
          S_STRING:           lex_fail(ST_BAD_STRING);
          S_SLASH, S_KEYWORD: lex_fail(ST_UNKNOWN);
          default: ;
        endcase
      end
      step_results.push_back(res(ST_END, K_LBRACK, pos, 16'd0));
      lexer_clear();
      return;
    end
    if (!lx_halted) begin
      case (lx_state)
        S_SLASH: begin
          if (ch == CH_SLASH) lx_state = S_LINE;
          else if (ch == CH_STAR) lx_state = S_BLOCK;
          else lex_fail(ST_UNKNOWN);
        end
        S_LINE: if (ch == CH_NL) lx_state = S_IDLE;
        S_BLOCK: if (ch == CH_STAR) lx_state = S_BSTAR;
        S_BSTAR: begin
          if (ch == CH_SLASH) lx_state = S_IDLE;
          else if (ch != CH_STAR) lx_state = S_BLOCK;
        end
        S_STRING: begin
          if (ch == CH_QUOTE && !lx_escaped) begin
            step_results.push_back(res(ST_TOKEN, K_STRING, lx_start,
                                       sat_next(pos) - lx_start));
            lx_state = S_IDLE;
          end
          lx_escaped = (ch == CH_BACKSLASH);
        end
        S_KEYWORD: begin
          word = keyword_text(lx_kw_sel);
          if (lx_kw_pos >= word.len() || word[lx_kw_pos] != ch) begin
            lex_fail(ST_UNKNOWN);
          end else begin
            lx_kw_pos = lx_kw_pos + 3'd1;
            if (lx_kw_pos == word.len()) begin
              kw_kind = (lx_kw_sel == KW_FALSE) ? K_FALSE :
                        (lx_kw_sel == KW_NULL)  ? K_NULL  : K_TRUE;
              step_results.push_back(res(ST_TOKEN, kw_kind, lx_start,
                                         sat_next(pos) - lx_start));
              lx_state  = S_IDLE;
              lx_kw_pos = 3'd0;
            end
          end
        end
        S_NMINUS: begin
          if (ch == CH_0) lx_state = S_NZERO;
          else if (is_digit(ch)) lx_state = S_NINT;
          else lex_fail(ST_BAD_NUMBER);
        end
        S_NZERO: begin
          if (ch == CH_DOT) lx_state = S_NDOT;
          else number_done(K_INT, ch, pos);
        end
        S_NINT: begin
          if (ch == CH_DOT) lx_state = S_NDOT;
          else if (!is_digit(ch)) number_done(K_INT, ch, pos);
        end
        S_NDOT: begin
          if (is_digit(ch)) lx_state = S_NFRAC;
          else lex_fail(ST_BAD_NUMBER);
        end
        S_NFRAC: if (!is_digit(ch)) number_done(K_REAL, ch, pos);
        default: begin
          lx_state = S_IDLE;
          lex_fresh(ch, pos);
        end
      endcase
    end
    lx_offset = sat_next(lx_offset);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH at result %0d: %s", results_seen, what);
  endtask

  // Present one beat, hold it until accepted, then predict what it causes
  task automatic send_beat(input logic [7:0] ch, input logic eot);
    while (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    lex_predict(ch, eot);
  endtask

  task automatic feed(input logic [7:0] ch, input logic eot);
    logic live;
    live = eot || !lx_halted;
    send_beat(ch, eot);
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
    if (live) live_beats++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input logic typed,
                         input logic [1:0] n, input result_t r0, input result_t r1);
    dir_row_t row;
    row.ch    = ch;
    row.eot   = eot;
    row.typed = typed;
    row.n     = n;
    row.r0    = r0;
    row.r1    = r1;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0:       return CH_TAB;
      1:       return CH_NL;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_0 + $urandom_range(9));
  endfunction

  // Mostly well-formed lexemes with random content, a few broken ones
  function automatic void make_fragment();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    string       word;
    frag_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 14) begin
      case ($urandom_range(5))
        0: frag_bytes.push_back(CH_LBRACK);
        1: frag_bytes.push_back(CH_RBRACK);
        2: frag_bytes.push_back(CH_LBRACE);
        3: frag_bytes.push_back(CH_RBRACE);
        4: frag_bytes.push_back(CH_COMMA);
        default: frag_bytes.push_back(CH_COLON);
      endcase
    end else if (pick < 26) begin
      n = $urandom_range(1, 3);
      repeat (n) frag_bytes.push_back(pick_blank());
    end else if (pick < 40) begin
      frag_bytes.push_back(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
        case ($urandom_range(9))
          0, 1: frag_bytes.push_back(CH_BACKSLASH);
          2: begin
            frag_bytes.push_back(CH_BACKSLASH);
            frag_bytes.push_back(CH_QUOTE);
          end
          3: frag_bytes.push_back(8'($urandom_range(255)));
          default: frag_bytes.push_back(8'($urandom_range(32, 126)));
        endcase
      end
      frag_bytes.push_back(CH_QUOTE);
    end else if (pick < 56) begin
      if ($urandom_range(3) == 0) frag_bytes.push_back(CH_MINUS);
      if ($urandom_range(3) == 0) begin
        frag_bytes.push_back(CH_0);
      end else begin
        frag_bytes.push_back(8'(CH_0 + $urandom_range(1, 9)));
        n = $urandom_range(0, 4);
        repeat (n) frag_bytes.push_back(pick_digit());
      end
      if ($urandom_range(2) == 0) begin
        frag_bytes.push_back(CH_DOT);
        n = $urandom_range(1, 3);
        repeat (n) frag_bytes.push_back(pick_digit());
      end
    end else if (pick < 68) begin
      word = keyword_text(2'($urandom_range(2)));
      for (int k = 0; k < word.len(); k++) frag_bytes.push_back(word[k]);
    end else if (pick < 75) begin
      frag_bytes.push_back(CH_SLASH);
      frag_bytes.push_back(CH_SLASH);
      n = $urandom_range(0, 10);
      repeat (n) begin
        b = 8'($urandom_range(255));
        frag_bytes.push_back((b == CH_NL) ? CH_SPACE : b);
      end
      frag_bytes.push_back(CH_NL);
    end else if (pick < 82) begin
      frag_bytes.push_back(CH_SLASH);
      frag_bytes.push_back(CH_STAR);
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(3))
          0: frag_bytes.push_back(CH_STAR);
          1: frag_bytes.push_back(CH_SLASH);
          2: frag_bytes.push_back(pick_blank());
          default: frag_bytes.push_back(8'($urandom_range(255)));
        endcase
      end
      frag_bytes.push_back(CH_STAR);
      frag_bytes.push_back(CH_SLASH);
    end else if (pick < 86) begin
      // leading zero splits the digits into two integers
      frag_bytes.push_back(CH_0);
      frag_bytes.push_back(pick_digit());
    end else if (pick < 89) begin
      frag_bytes.push_back(8'($urandom_range(255)));
    end else if (pick < 91) begin
      if ($urandom_range(1) == 0) begin
        frag_bytes.push_back(CH_MINUS);
      end else begin
        frag_bytes.push_back(pick_digit());
        frag_bytes.push_back(CH_DOT);
      end
      frag_bytes.push_back(8'($urandom_range(255)));
    end else if (pick < 93) begin
      word = keyword_text(2'($urandom_range(2)));
      n = $urandom_range(1, word.len() - 1);
      for (int k = 0; k < n; k++) frag_bytes.push_back(word[k]);
      frag_bytes.push_back(8'($urandom_range(255)));
    end else if (pick < 94) begin
      frag_bytes.push_back(CH_SLASH);
      frag_bytes.push_back(8'($urandom_range(255)));
    end else begin
      frag_bytes.push_back(CH_SPACE);
    end
  endfunction

  task automatic gen_text();
    int unsigned nfrag;
    int unsigned keep;
    nfrag = $urandom_range(0, 12);
    for (int f = 0; f < nfrag; f++) begin
      make_fragment();
      keep = frag_bytes.size();
      // now and then end the text inside a construct
      if ($urandom_range(19) == 0) keep = $urandom_range(1, frag_bytes.size());
      for (int i = 0; i < keep; i++) feed(frag_bytes[i], 1'b0);
      if (keep < frag_bytes.size()) break;
    end
    feed(8'($urandom_range(255)), 1'b1);
    texts_sent++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("json_token_lexer test failed");
      $finish;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      case (m_axis_tuser_o)
        ST_TOKEN: tokens_seen++;
        ST_END:   ends_seen++;
        default:  errors_seen++;
      endcase
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d", m_axis_tuser_o));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", m_axis_tuser_o, want.status));
        if (m_axis_tdata_o[3:0] !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", m_axis_tdata_o[3:0], want.kind));
        if (m_axis_tdata_o[19:4] !== want.start)
          flag_mismatch($sformatf("start %0d, want %0d", m_axis_tdata_o[19:4], want.start));
        if (m_axis_tdata_o[35:20] !== want.len)
          flag_mismatch($sformatf("length %0d, want %0d", m_axis_tdata_o[35:20], want.len));
        if (m_axis_tdata_o[39:36] !== 4'd0)
          flag_mismatch($sformatf("pad bits %h", m_axis_tdata_o[39:36]));
      end
    end
    m_axis_tready_i <= calm || ($urandom_range(99) >= 14);
  end

  initial begin
    lexer_clear();

    add_row(8'h00, 1'b1, 1'b1, 2'd1, res(ST_END, K_LBRACK, 16'd0, 16'd0), '0);
    add_row(CH_LBRACK, 1'b0, 1'b1, 2'd1, res(ST_TOKEN, K_LBRACK, 16'd0, 16'd1), '0);
    add_row(8'hFF, 1'b0, 1'b1, 2'd1, res(ST_UNKNOWN, K_LBRACK, 16'd1, 16'd0), '0);
    add_row(CH_RBRACK, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b1, 2'd1, res(ST_END, K_LBRACK, 16'd3, 16'd0), '0);
    add_row(8'h00, 1'b0, 1'b1, 2'd1, res(ST_UNKNOWN, K_LBRACK, 16'd0, 16'd0), '0);
    add_row(8'h00, 1'b1, 1'b1, 2'd1, res(ST_END, K_LBRACK, 16'd1, 16'd0), '0);
    add_row(CH_MINUS, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'h55, 1'b1, 1'b1, 2'd2, res(ST_BAD_NUMBER, K_LBRACK, 16'd0, 16'd0),
            res(ST_END, K_LBRACK, 16'd1, 16'd0));
    add_row(CH_0 + 8'd1, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CH_0 + 8'd2, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CH_DOT, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CH_0 + 8'd5, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CH_COMMA, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CH_0, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CH_0 + 8'd1, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(8'hA5, 1'b1, 1'b0, 2'd0, '0, '0);
    add_row(CH_SLASH, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'h5A, 1'b1, 1'b1, 2'd2, res(ST_UNKNOWN, K_LBRACK, 16'd0, 16'd0),
            res(ST_END, K_LBRACK, 16'd1, 16'd0));
    add_row(CH_QUOTE, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'h00, 1'b1, 1'b1, 2'd2, res(ST_BAD_STRING, K_LBRACK, 16'd0, 16'd0),
            res(ST_END, K_LBRACK, 16'd1, 16'd0));
    add_row(CH_SLASH, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(CH_STAR, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'h00, 1'b1, 1'b1, 2'd2, res(ST_OPEN_COMMENT, K_LBRACK, 16'd0, 16'd0),
            res(ST_END, K_LBRACK, 16'd2, 16'd0));
    add_row(CH_N, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'hFF, 1'b1, 1'b1, 2'd2, res(ST_UNKNOWN, K_LBRACK, 16'd0, 16'd0),
            res(ST_END, K_LBRACK, 16'd1, 16'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].ch, dir_rows[i].eot);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].n > 2'd0) pending_results.push_back(dir_rows[i].r0);
        if (dir_rows[i].n > 2'd1) pending_results.push_back(dir_rows[i].r1);
      end else begin
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
      end
    end

    live_beats = 0;
    while (live_beats < RANDOM_BEATS) begin
      calm = (live_beats >= 300 && live_beats < 550);
      gen_text();
    end
    calm = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d directed beats and %0d random texts (%0d live beats) under",
             dir_rows.size(), texts_sent, live_beats);
    $display("random stalls; checked %0d tokens, %0d errors, %0d end marks",
             tokens_seen, errors_seen, ends_seen);
    if (mismatches == 0) begin
      $display("json_token_lexer test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("json_token_lexer test failed");
    end
    $finish;
  end

endmodule

[json_token_lexer.f]
sv/jtl_pkg.sv
sv/jtl_scan.sv
sv/jtl_queue.sv
sv/json_token_lexer.sv
tb/sv/testbench.sv
